// File: rtl/lanf_pkg.sv
`timescale 1ns / 1ps

package lanf_pkg;

  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int STEP_WIDTH      = 15;
  localparam int REF_WIDTH       = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_SIZE  = 1'd1;

  localparam logic [STEP_WIDTH-1:0] STEP_SIZE_RESET = 15'd328;

  // Two pi in Q2.30.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [1:0] {
    MUL_EST,
    MUL_MU,
    MUL_UPD
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     err_en;
    logic     out_load;
    logic     wgt_en;
  } lanf_cmd_t;

  // One Taylor step: t * x^2, both multiplies truncated back to Q2.30.
  function automatic logic [63:0] taylor_next(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] u;
    u = (t * x) >> 30;
    return (u * x) >> 30;
  endfunction

  // Quarter-wave sine entry in Q1.15; evaluated only at elaboration.
  function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned tab_bits);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic signed [63:0] q;
    x = (64'(idx) * TWO_PI_Q30) >> tab_bits;
    t = x;
    s = $signed(t);
    t = taylor_next(t, x) / 64'd6;
    s = s - $signed(t);
    t = taylor_next(t, x) / 64'd20;
    s = s + $signed(t);
    t = taylor_next(t, x) / 64'd42;
    s = s - $signed(t);
    t = taylor_next(t, x) / 64'd72;
    s = s + $signed(t);
    t = taylor_next(t, x) / 64'd110;
    s = s - $signed(t);
    t = taylor_next(t, x) / 64'd156;
    s = s + $signed(t);
    if (s < 0) begin
      s = '0;
    end
    q = (s + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[14:0];
  endfunction

endpackage

// File: rtl/lanf_ctrl.sv
`timescale 1ns / 1ps

module lanf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lanf_pkg::lanf_cmd_t cmd
);
  import lanf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EST  = 6'b000010,
    S_ERR  = 6'b000100,
    S_MU   = 6'b001000,
    S_UPD  = 6'b010000,
    S_WGT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;
  logic   accept;
  logic   out_free;

  // The weight write in S_WGT lands before the next item's estimate, so a
  // new item may enter there.
  assign ready    = (state == S_IDLE) || (state == S_WGT);
  assign in_stall = !ready;
  assign accept   = ready && in_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MUL_EST;
    cmd.load     = accept;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EST;
        end
      end
      S_EST: begin
        cmd.mul_sel = MUL_EST;
        state_next  = S_ERR;
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_next = S_MU;
      end
      S_MU: begin
        cmd.mul_sel  = MUL_MU;
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.mul_sel = MUL_UPD;
        state_next  = S_WGT;
      end
      S_WGT: begin
        cmd.wgt_en = 1'b1;
        state_next = accept ? S_EST : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/lanf_datapath.sv
`timescale 1ns / 1ps

module lanf_datapath #(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int PHASE_WIDTH        = 32,
  parameter int TABLE_ADDRESS_BITS = 10,
  parameter int WEIGHT_WIDTH       = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  lanf_pkg::lanf_cmd_t                     cmd,
  input  logic                                    cfg_wr_en,
  input  logic [lanf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [lanf_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]          sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]          filtered_sample
);
  import lanf_pkg::*;

  localparam int SW      = SAMPLE_WIDTH;
  localparam int WW      = WEIGHT_WIDTH;
  localparam int TAB     = TABLE_ADDRESS_BITS;
  localparam int QB      = TAB - 2;
  localparam int QUARTER = 1 << QB;
  localparam int AW      = (WW > SW + REF_WIDTH) ? WW : SW + REF_WIDTH;
  localparam int PRW     = AW + REF_WIDTH;
  localparam int DW      = PRW + 2;
  localparam int KE      = WW - SW + 13;
  localparam int KU      = 32 + SW - WW;
  localparam longint WINIT = ((64'sd1 <<< (WW - 3)) + 5) / 10;
  localparam logic signed [WW-1:0] WEIGHT_INIT = WW'(WINIT);
  localparam logic signed [DW-1:0] EST_HALF = DW'(1) << (KE - 1);
  localparam logic signed [DW-1:0] UPD_HALF = DW'(1) << (KU - 1);

  logic [14:0] sine_rom [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, TAB);
  end

  logic [PHASE_WIDTH-1:0]       phase_step;
  logic [STEP_WIDTH-1:0]        step_size;
  logic [PHASE_WIDTH-1:0]       phase;
  logic signed [WW-1:0]         cos_w;
  logic signed [WW-1:0]         sin_w;
  logic signed [SW-1:0]         sample_r;
  logic signed [REF_WIDTH-1:0]  ref_s;
  logic signed [REF_WIDTH-1:0]  ref_c;
  logic signed [SW-1:0]         err_r;
  logic signed [PRW-1:0]        p0;
  logic signed [PRW-1:0]        p1;

  logic [TAB-1:0]               lane_addr [2];
  logic [QB:0]                  lane_idx  [2];
  logic signed [REF_WIDTH-1:0]  lane_val  [2];
  logic [14:0]                  lane_mag  [2];

  // Lane 0 reads the sine, lane 1 the cosine a quarter turn ahead.
  assign lane_addr[0] = phase[PHASE_WIDTH-1 -: TAB];
  assign lane_addr[1] = phase[PHASE_WIDTH-1 -: TAB] + TAB'(QUARTER);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (lane_addr[l][QB]) begin
        lane_idx[l] = (QB+1)'(QUARTER) - {1'b0, lane_addr[l][QB-1:0]};
      end else begin
        lane_idx[l] = {1'b0, lane_addr[l][QB-1:0]};
      end
      lane_mag[l] = sine_rom[lane_idx[l]];
      if (lane_addr[l][TAB-1]) begin
        lane_val[l] = -$signed({1'b0, lane_mag[l]});
      end else begin
        lane_val[l] = $signed({1'b0, lane_mag[l]});
      end
    end
  end

  logic signed [AW-1:0]        a0;
  logic signed [AW-1:0]        a1;
  logic signed [REF_WIDTH-1:0] b0;
  logic signed [REF_WIDTH-1:0] b1;

  always_comb begin
    case (cmd.mul_sel)
      MUL_EST: begin
        a0 = AW'(cos_w);
        b0 = ref_c;
        a1 = AW'(sin_w);
        b1 = ref_s;
      end
      MUL_MU: begin
        a0 = AW'(err_r);
        b0 = $signed({1'b0, step_size});
        a1 = '0;
        b1 = '0;
      end
      MUL_UPD: begin
        // p0 holds step_size * error from the previous cycle.
        a0 = AW'($signed(p0[SW+REF_WIDTH-1:0]));
        b0 = ref_c;
        a1 = AW'($signed(p0[SW+REF_WIDTH-1:0]));
        b1 = ref_s;
      end
      default: begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
      end
    endcase
  end

  logic signed [DW-1:0] est_sum;
  logic signed [DW-1:0] est_rnd;
  logic signed [DW-1:0] err_wide;
  logic signed [SW-1:0] err_sat;
  logic signed [DW-1:0] dc_sum;
  logic signed [DW-1:0] ds_sum;
  logic signed [DW-1:0] wc_wide;
  logic signed [DW-1:0] ws_wide;
  logic signed [WW-1:0] wc_sat;
  logic signed [WW-1:0] ws_sat;

  always_comb begin
    est_sum  = DW'(p0) + DW'(p1) + EST_HALF;
    est_rnd  = est_sum >>> KE;
    err_wide = DW'(sample_r) - est_rnd;
    if (&err_wide[DW-1:SW-1] || ~|err_wide[DW-1:SW-1]) begin
      err_sat = err_wide[SW-1:0];
    end else begin
      err_sat = err_wide[DW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end

    dc_sum  = (DW'(p0) + UPD_HALF) >>> KU;
    ds_sum  = (DW'(p1) + UPD_HALF) >>> KU;
    wc_wide = DW'(cos_w) + dc_sum;
    ws_wide = DW'(sin_w) + ds_sum;
    if (&wc_wide[DW-1:WW-1] || ~|wc_wide[DW-1:WW-1]) begin
      wc_sat = wc_wide[WW-1:0];
    end else begin
      wc_sat = wc_wide[DW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end
    if (&ws_wide[DW-1:WW-1] || ~|ws_wide[DW-1:WW-1]) begin
      ws_sat = ws_wide[WW-1:0];
    end else begin
      ws_sat = ws_wide[DW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      step_size  <= STEP_SIZE_RESET;
      phase      <= '0;
      cos_w      <= WEIGHT_INIT;
      sin_w      <= WEIGHT_INIT;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PHASE_STEP: phase_step <= cfg_data[PHASE_WIDTH-1:0];
          REG_STEP_SIZE:  step_size  <= cfg_data[STEP_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        phase <= phase + phase_step;
      end
      if (cmd.wgt_en) begin
        cos_w <= wc_sat;
        sin_w <= ws_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    p0 <= PRW'(a0 * b0);
    p1 <= PRW'(a1 * b1);
    if (cmd.load) begin
      sample_r <= sample_in;
      ref_s    <= lane_val[0];
      ref_c    <= lane_val[1];
    end
    if (cmd.err_en) begin
      err_r <= err_sat;
    end
    if (cmd.out_load) begin
      filtered_sample <= err_r;
    end
  end

endmodule

// File: rtl/lms_adaptive_notch_filter_top.sv
`timescale 1ns / 1ps

// Two-weight LMS notch: removes one tone, set by phase_step, from a stream of
// signed samples. Each input item on sample_in gives exactly one output item
// on filtered_sample, the sample minus the current tone estimate.
// Both channels use valid/stall; an item moves on a clock edge with valid
// high and stall low. Configuration is a write port (cfg_wr_en, cfg_index,
// cfg_data): index 0 is phase_step, index 1 is step_size. Write it only
// while no item is in flight.
// An item passes the estimate, error and step-scaling states; out_valid is
// registered as it leaves step scaling. Inputs are taken while idle or in the
// weight-write step of the weight recurrence on two shared multipliers
// (estimate, error, step scaling, update, weight write). The output sits in
// its own register, so the next input is taken while a result still waits; a
// stalled output only holds the item after it in the step-scaling cycle.
// Reset (rst, synchronous) clears the phase, restores both weights to 0.1 and
// step_size to 328, and empties the output.
module lms_adaptive_notch_filter_top #(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int PHASE_WIDTH        = 32,
  parameter int TABLE_ADDRESS_BITS = 10,
  parameter int WEIGHT_WIDTH       = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [lanf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lanf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       filtered_sample
);
  import lanf_pkg::*;

  lanf_cmd_t cmd;

  lanf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lanf_datapath #(
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .PHASE_WIDTH        (PHASE_WIDTH),
    .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS),
    .WEIGHT_WIDTH       (WEIGHT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_in       (sample_in),
    .filtered_sample (filtered_sample)
  );

endmodule

// File: rtl/lanf_checker.sv
`timescale 1ns / 1ps

module lanf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] filtered_sample
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items taken but not yet delivered; at most one in work and one waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty and ready after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again before the weight update finished");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output valid with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more items outstanding than the block can hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_sample))
    else $error("stalled output item changed");

endmodule

bind lms_adaptive_notch_filter_top lanf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lanf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .filtered_sample (filtered_sample)
);
